// ===== rtl/lsmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline mode timer package
// Shared types and timing constants for the scanline mode timer.
// ----------------------------------------------------------------------------
package lsmt_pkg;

  // Line timing constants and last line numbers.
  localparam logic [15:0] LINE_CYCLES  = 16'd456;
  localparam logic [15:0] OAM_END      = 16'd80;
  localparam logic [15:0] XFER_END     = 16'd256;
  localparam logic [7:0]  LAST_LINE    = 8'd153;
  localparam logic [7:0]  LAST_VISIBLE = 8'd143;

  // Frame skip limits.
  localparam logic [4:0]  SKIP_MIN     = 5'd1;
  localparam logic [4:0]  SKIP_MAX     = 5'd16;
  localparam logic [4:0]  SKIP_RESET   = 5'd1;

  // Display mode codes.
  localparam logic [1:0]  MODE_HBLANK  = 2'd0;
  localparam logic [1:0]  MODE_VBLANK  = 2'd1;
  localparam logic [1:0]  MODE_OAM     = 2'd2;
  localparam logic [1:0]  MODE_XFER    = 2'd3;

  // Status interrupt enable bit positions.
  localparam int unsigned EN_HBLANK    = 0;
  localparam int unsigned EN_VBLANK    = 1;
  localparam int unsigned EN_OAM       = 2;
  localparam int unsigned EN_COMPARE   = 3;

  typedef struct packed {
    logic [7:0] cycles_elapsed;
    logic       display_on;
    logic [7:0] compare_line;
    logic [3:0] stat_enables;
  } item_t;

  typedef struct packed {
    logic [15:0] cycle_count;
    logic [7:0]  line_number;
    logic [1:0]  current_mode;
    logic        render_this_frame;
    logic [3:0]  frame_phase;
    logic        compare_fired;
  } timer_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       stat_written;
    logic [2:0] stat_flags;
    logic       stat_interrupt;
    logic       vblank_interrupt;
    logic       hdma_request;
    logic       oam_scan_request;
    logic       render_request;
    logic [7:0] current_line;
    logic       line_written;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/lcd_scanline_mode_timer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline mode timer core
// Display mode and status timing for one scanline counter, one result per
// input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one transaction per
//   emulated CPU step: the elapsed cycles, the display enable bit, the line
//   compare value and the status interrupt enables. The output channel
//   (out_valid / out_stall) returns exactly one result transaction for each
//   input transaction, in order.
//   A transaction is first captured in an input register. The step logic
//   then uses it together with the timer state once the output register has
//   room; the state is updated and the result is captured in the output
//   register at that same edge. The block sustains one transaction per cycle
//   while the receiver does not stall.
//   When the receiver stalls, the result register holds; the input register
//   still accepts one further transaction, after which in_stall is raised
//   until the result is taken.
//   The frame skip register is written through cfg_valid / cfg_ready /
//   cfg_data. cfg_ready is always high; writes are meant to happen only while
//   no transaction is in flight.
//   Reset (rst, synchronous) empties both registers, sets frame skip to one
//   and returns the timer to line zero, cycle zero, hblank, with rendering on.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // Configuration write channel.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] cycles_elapsed,
  input  wire logic       display_on,
  input  wire logic [7:0] compare_line,
  input  wire logic [3:0] stat_enables,
  // Output channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      mode,
  output logic            stat_written,
  output logic [2:0]      stat_flags,
  output logic            stat_interrupt,
  output logic            vblank_interrupt,
  output logic            hdma_request,
  output logic            oam_scan_request,
  output logic            render_request,
  output logic [7:0]      current_line,
  output logic            line_written
);

  logic                   cfg_write;
  logic [4:0]             frame_skip;
  logic                   in_full;
  lsmt_pkg::item_t        in_item;
  lsmt_pkg::timer_state_t st;
  lsmt_pkg::timer_state_t st_next;
  lsmt_pkg::result_t      res_next;
  lsmt_pkg::result_t      res;
  logic                   out_adv;
  logic                   step_go;

  // The output register can take a new result when empty or being drained.
  assign out_adv   = !out_valid || !out_stall;
  // The held transaction moves into the step logic when the result has room.
  assign step_go   = in_full && out_adv;
  assign in_stall  = in_full && !out_adv;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_skip <= lsmt_pkg::SKIP_RESET;
    end else if (cfg_write) begin
      frame_skip <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.cycles_elapsed <= cycles_elapsed;
      in_item.display_on     <= display_on;
      in_item.compare_line   <= compare_line;
      in_item.stat_enables   <= stat_enables;
    end
  end

  lsmt_step u_step (
    .frame_skip (frame_skip),
    .item       (in_item),
    .st         (st),
    .st_next    (st_next),
    .res        (res_next)
  );

  // Timer state advances once per transaction that reaches the step logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cycle_count       <= 16'd0;
      st.line_number       <= 8'd0;
      st.current_mode      <= lsmt_pkg::MODE_HBLANK;
      st.render_this_frame <= 1'b1;
      st.frame_phase       <= 4'd0;
      st.compare_fired     <= 1'b0;
    end else if (step_go) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res <= res_next;
    end
  end

  assign mode             = res.mode;
  assign stat_written     = res.stat_written;
  assign stat_flags       = res.stat_flags;
  assign stat_interrupt   = res.stat_interrupt;
  assign vblank_interrupt = res.vblank_interrupt;
  assign hdma_request     = res.hdma_request;
  assign oam_scan_request = res.oam_scan_request;
  assign render_request   = res.render_request;
  assign current_line     = res.current_line;
  assign line_written     = res.line_written;

  // A stalled input can only come from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register had room");

  // The line counter never leaves the frame.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    st.line_number <= lsmt_pkg::LAST_LINE)
    else $error("line number beyond last line");

  // The vblank interrupt only comes with a recorded change into vblank.
  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && vblank_interrupt) |->
      (stat_written && mode == lsmt_pkg::MODE_VBLANK))
    else $error("vblank interrupt without vblank entry");

  // HDMA and render requests match the mode they belong to.
  a_request_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (hdma_request || render_request)) |->
      (stat_written &&
       ((hdma_request && mode == lsmt_pkg::MODE_HBLANK) ||
        (render_request && mode == lsmt_pkg::MODE_XFER))))
    else $error("request raised outside its mode entry");

  // A result is in the output register in the cycle after the step fires.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step_go |=> out_valid)
    else $error("result lost after step");

endmodule
`default_nettype wire

// ===== rtl/lsmt_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline mode timer step
// Combinational next-state and result logic for one transaction.
// ----------------------------------------------------------------------------
module lsmt_step (
  input  wire logic [4:0]            frame_skip,
  input  wire lsmt_pkg::item_t       item,
  input  wire lsmt_pkg::timer_state_t st,
  output lsmt_pkg::timer_state_t     st_next,
  output lsmt_pkg::result_t          res
);

  logic [16:0] sum;
  logic [15:0] cyc_sat;
  logic [1:0]  mode_found;
  logic        match;
  logic        render_now;
  logic [7:0]  line_inc;
  logic [4:0]  phase_inc;
  logic [4:0]  skip_val;

  always_comb begin
    // Saturating accumulate of elapsed cycles.
    sum     = {1'b0, st.cycle_count} + {9'd0, item.cycles_elapsed};
    cyc_sat = sum[16] ? 16'hFFFF : sum[15:0];

    if (st.line_number > lsmt_pkg::LAST_VISIBLE) begin
      mode_found = lsmt_pkg::MODE_VBLANK;
    end else if (cyc_sat < lsmt_pkg::OAM_END) begin
      mode_found = lsmt_pkg::MODE_OAM;
    end else if (cyc_sat < lsmt_pkg::XFER_END) begin
      mode_found = lsmt_pkg::MODE_XFER;
    end else begin
      mode_found = lsmt_pkg::MODE_HBLANK;
    end

    match = (item.compare_line == st.line_number);

    if (frame_skip < lsmt_pkg::SKIP_MIN) begin
      skip_val = lsmt_pkg::SKIP_MIN;
    end else if (frame_skip > lsmt_pkg::SKIP_MAX) begin
      skip_val = lsmt_pkg::SKIP_MAX;
    end else begin
      skip_val = frame_skip;
    end

    line_inc   = st.line_number + 8'd1;
    phase_inc  = {1'b0, st.frame_phase} + 5'd1;
    render_now = st.render_this_frame;

    st_next             = st;
    st_next.cycle_count = cyc_sat;

    res              = '0;
    res.current_line = st.line_number;

    if (item.display_on) begin
      if (mode_found != st.current_mode) begin
        st_next.current_mode = mode_found;
        res.stat_written     = 1'b1;
        res.stat_flags       = {match, mode_found};

        if (match && item.stat_enables[lsmt_pkg::EN_COMPARE] && !st.compare_fired) begin
          res.stat_interrupt    = 1'b1;
          st_next.compare_fired = 1'b1;
        end
        if ((mode_found == lsmt_pkg::MODE_HBLANK && item.stat_enables[lsmt_pkg::EN_HBLANK]) ||
            (mode_found == lsmt_pkg::MODE_VBLANK && item.stat_enables[lsmt_pkg::EN_VBLANK]) ||
            (mode_found == lsmt_pkg::MODE_OAM    && item.stat_enables[lsmt_pkg::EN_OAM])) begin
          res.stat_interrupt = 1'b1;
        end

        if (mode_found == lsmt_pkg::MODE_HBLANK) begin
          res.hdma_request = 1'b1;
        end
        if (mode_found == lsmt_pkg::MODE_VBLANK) begin
          // Decide at vblank entry whether the coming frame is drawn.
          render_now               = (st.frame_phase == 4'd0);
          st_next.render_this_frame = render_now;
          res.vblank_interrupt     = 1'b1;
        end
        res.oam_scan_request = render_now && (mode_found == lsmt_pkg::MODE_OAM);
        res.render_request   = render_now && (mode_found == lsmt_pkg::MODE_XFER);
      end

      if (cyc_sat >= lsmt_pkg::LINE_CYCLES) begin
        res.line_written      = 1'b1;
        st_next.compare_fired = 1'b0;
        st_next.cycle_count   = cyc_sat - lsmt_pkg::LINE_CYCLES;
        if (line_inc > lsmt_pkg::LAST_LINE || line_inc == 8'd0) begin
          st_next.line_number = 8'd0;
          st_next.frame_phase = (phase_inc >= skip_val) ? 4'd0 : phase_inc[3:0];
        end else begin
          st_next.line_number = line_inc;
        end
      end
    end

    res.mode = st_next.current_mode;
  end

endmodule
`default_nettype wire
